### design/ffrc_pkg.sv
// Package for the fixed frame receiver with additive checksum.
// Holds the frame geometry, marker bytes, command and status codes.
// No dependencies.
`default_nettype none

package ffrc_pkg;

    // Frame geometry.
    localparam int unsigned FRAME_LEN  = 10;
    localparam int unsigned CNT_W      = $clog2(FRAME_LEN);

    // Marker bytes and their positions in the frame.
    localparam logic [7:0] DLE_BYTE = 8'h10;
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ADR_BYTE = 8'h01;
    localparam logic [7:0] ETX_BYTE = 8'h03;

    localparam int unsigned POS_DLE0  = 0;
    localparam int unsigned POS_STX   = 1;
    localparam int unsigned POS_DATA0 = 2;
    localparam int unsigned POS_DATA1 = 3;
    localparam int unsigned POS_ADR   = 4;
    localparam int unsigned POS_DATA2 = 5;
    localparam int unsigned POS_DATA3 = 6;
    localparam int unsigned POS_DLE1  = 7;
    localparam int unsigned POS_ETX   = 8;

    // Timeout register.
    localparam int unsigned  TIMEOUT_W     = 16;
    localparam logic [15:0]  TIMEOUT_RESET = 16'd300;

    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_SPARE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_GOOD     = 3'd1,
        ST_BAD_MARK = 3'd2,
        ST_BAD_SUM  = 3'd3,
        ST_DROPPED  = 3'd4,
        ST_TICK     = 3'd5,
        ST_FLUSH    = 3'd6,
        ST_RELEASED = 3'd7
    } status_t;

endpackage

`default_nettype wire

### design/fixed_frame_receiver_checksum.sv
// Top level of the fixed frame receiver with additive checksum.
// Depends on ffrc_pkg for frame geometry, marker bytes and codes.
// Single module: state registers, next-state logic and result register.
`default_nettype none

// The receiver gathers bytes into a ten-byte frame and, when the tenth byte
// arrives, checks the marker bytes (0x10, 0x02 at the head, 0x01 in the
// middle, 0x10, 0x03 at the tail) and compares the 8-bit wrapping sum of
// bytes 2 to 6 with byte 9. A good frame raises busy and reports bytes 2, 3,
// 5 and 6; bytes received while busy are dropped until a release command
// arrives. Timer ticks age a partial frame, which is flushed when the age
// reaches the value written on the configuration port (300 after reset; a
// value of 0 means 65536 ticks). Every accepted transfer produces exactly
// one result transfer. The state update and the result are computed in
// one pass of short logic and the result is captured in an output
// register, so a new transfer is taken in every cycle in which that
// register is empty or is being drained. The result appears in the cycle
// after acceptance. There is no clearing pass after reset, and the
// configuration port is always ready.
module fixed_frame_receiver_checksum (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  rx_byte,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [7:0]       payload_a,
    output logic [7:0]       payload_b,
    output logic [7:0]       payload_c,
    output logic [7:0]       payload_d,
    output logic             busy_flag,
    // Configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    // Frame store. Every entry that the checks read is rewritten before a
    // frame completes, so the store needs no reset and is never cleared: a
    // bad or flushed frame only rewinds the byte counter and the age.
    logic [7:0] store_reg [ffrc_pkg::FRAME_LEN];

    logic [ffrc_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [ffrc_pkg::TIMEOUT_W-1:0] linger_reg, linger_next;
    logic [ffrc_pkg::TIMEOUT_W-1:0] linger_inc;
    logic [ffrc_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                           busy_reg, busy_next;

    // Result register.
    logic                     out_valid_reg;
    ffrc_pkg::status_t        status_reg, status_next;
    logic [7:0]               pay_a_reg, pay_b_reg, pay_c_reg, pay_d_reg;
    logic [7:0]               pay_a_next, pay_b_next, pay_c_next, pay_d_next;
    logic                     busy_out_reg;

    logic                     accept;
    logic                     store_we;
    logic                     last_byte;
    logic                     marks_ok;
    logic [7:0]               sum;
    ffrc_pkg::cmd_t           cmd;

    // The output register parts the two sides: a new transfer is taken
    // whenever the pending result leaves in the same cycle or none waits.
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cmd       = ffrc_pkg::cmd_t'(command);

    assign last_byte = (count_reg == ffrc_pkg::CNT_W'(ffrc_pkg::FRAME_LEN - 1));

    // Marker check and checksum on the completed frame; byte 9 is the byte
    // arriving now and is not yet in the store.
    assign marks_ok = (store_reg[ffrc_pkg::POS_DLE0] == ffrc_pkg::DLE_BYTE) &&
                      (store_reg[ffrc_pkg::POS_STX]  == ffrc_pkg::STX_BYTE) &&
                      (store_reg[ffrc_pkg::POS_ADR]  == ffrc_pkg::ADR_BYTE) &&
                      (store_reg[ffrc_pkg::POS_DLE1] == ffrc_pkg::DLE_BYTE) &&
                      (store_reg[ffrc_pkg::POS_ETX]  == ffrc_pkg::ETX_BYTE);

    assign sum = store_reg[ffrc_pkg::POS_DATA0] + store_reg[ffrc_pkg::POS_DATA1] +
                 store_reg[ffrc_pkg::POS_ADR]   + store_reg[ffrc_pkg::POS_DATA2] +
                 store_reg[ffrc_pkg::POS_DATA3];

    assign linger_inc = linger_reg + ffrc_pkg::TIMEOUT_W'(1);

    always_comb
    begin
        count_next  = count_reg;
        linger_next = linger_reg;
        busy_next   = busy_reg;
        store_we    = 1'b0;
        status_next = ffrc_pkg::ST_TICK;
        pay_a_next  = 8'd0;
        pay_b_next  = 8'd0;
        pay_c_next  = 8'd0;
        pay_d_next  = 8'd0;

        unique case (cmd)
            ffrc_pkg::CMD_BYTE:
            begin
                if (busy_reg)
                begin
                    status_next = ffrc_pkg::ST_DROPPED;
                end
                else if (last_byte)
                begin
                    store_we    = 1'b1;
                    count_next  = '0;
                    linger_next = '0;
                    if (!marks_ok)
                    begin
                        status_next = ffrc_pkg::ST_BAD_MARK;
                    end
                    else if (sum != rx_byte)
                    begin
                        status_next = ffrc_pkg::ST_BAD_SUM;
                    end
                    else
                    begin
                        status_next = ffrc_pkg::ST_GOOD;
                        busy_next   = 1'b1;
                        pay_a_next  = store_reg[ffrc_pkg::POS_DATA0];
                        pay_b_next  = store_reg[ffrc_pkg::POS_DATA1];
                        pay_c_next  = store_reg[ffrc_pkg::POS_DATA2];
                        pay_d_next  = store_reg[ffrc_pkg::POS_DATA3];
                    end
                end
                else
                begin
                    store_we    = 1'b1;
                    count_next  = count_reg + ffrc_pkg::CNT_W'(1);
                    status_next = ffrc_pkg::ST_STORED;
                end
            end
            ffrc_pkg::CMD_TICK:
            begin
                // Only a partial frame that is not waiting for release ages.
                if (count_reg != '0 && !busy_reg)
                begin
                    if (linger_inc == timeout_reg)
                    begin
                        linger_next = '0;
                        count_next  = '0;
                        status_next = ffrc_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        linger_next = linger_inc;
                    end
                end
            end
            ffrc_pkg::CMD_RELEASE:
            begin
                busy_next   = 1'b0;
                status_next = ffrc_pkg::ST_RELEASED;
            end
            ffrc_pkg::CMD_SPARE:
            begin
                status_next = ffrc_pkg::ST_TICK;
            end
            default:
            begin
                status_next = ffrc_pkg::ST_TICK;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            linger_reg    <= '0;
            busy_reg      <= 1'b0;
            timeout_reg   <= ffrc_pkg::TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                linger_reg    <= linger_next;
                busy_reg      <= busy_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Frame store and result payload.
    always_ff @(posedge clk)
    begin
        if (accept && store_we)
        begin
            for (int i = 0; i < ffrc_pkg::FRAME_LEN; i++)
            begin
                if (count_reg == ffrc_pkg::CNT_W'(i))
                begin
                    store_reg[i] <= rx_byte;
                end
            end
        end
        if (accept)
        begin
            status_reg   <= status_next;
            pay_a_reg    <= pay_a_next;
            pay_b_reg    <= pay_b_next;
            pay_c_reg    <= pay_c_next;
            pay_d_reg    <= pay_d_next;
            busy_out_reg <= busy_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign payload_a = pay_a_reg;
    assign payload_b = pay_b_reg;
    assign payload_c = pay_c_reg;
    assign payload_d = pay_d_reg;
    assign busy_flag = busy_out_reg;

    // The byte counter never runs past the last position of the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < ffrc_pkg::CNT_W'(ffrc_pkg::FRAME_LEN))
        else $error("byte counter beyond frame length");

    // A byte accepted while busy must be reported as dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && busy_reg && cmd == ffrc_pkg::CMD_BYTE
        |=> out_valid && status == ffrc_pkg::ST_DROPPED)
        else $error("byte taken while busy was not dropped");

    // A good frame always leaves the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ffrc_pkg::ST_GOOD |-> busy_flag && busy_reg)
        else $error("good frame reported without busy");

    // Payload fields stay zero unless a good frame is reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ffrc_pkg::ST_GOOD
        |-> (payload_a | payload_b | payload_c | payload_d) == 8'd0)
        else $error("payload present without a good frame");

endmodule

`default_nettype wire
